// ===== rtl/core/multilevel_feedback_scheduler_unit_assert.svh =====
// Assertion macros shared by the scheduler modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MSCHED_CHECK(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("msched: check failed");

// Next-cycle implication.
`define MSCHED_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("msched: next-cycle check failed");

`endif

// ===== rtl/core/msched_pkg.sv =====
`default_nettype none
package msched_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LEVELS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM0   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM3   = 3'd5;

   localparam int QUANTA  = 4;
   localparam int LEVEL_W = 2;
   localparam int LCNT_W  = 3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  proc_id;
      logic [15:0] arrival;
      logic [15:0] burst;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] tick_time;
      logic        ran;
      logic [7:0]  run_pid;
      logic [1:0]  run_level;
      logic        finished;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic [31:0] response;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic tick_start;
      logic scan;
      logic update;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/msched_chan_if.sv =====
`default_nettype none
interface msched_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/msched_ram.sv =====
`default_nettype none
module msched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/msched_ctrl.sv =====
`default_nettype none
module msched_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_type,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   input  wire msched_pkg::sts_type  sts,
   output msched_pkg::cmd_type       cmd
);
   import msched_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_REPORT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  REQ_LOAD:  cmd.load = 1'b1;
                  REQ_CLEAR: cmd.clear = 1'b1;
                  REQ_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_REPORT;
         end
         ST_REPORT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.report   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`include "multilevel_feedback_scheduler_unit_assert.svh"
   `MSCHED_CHECK(a_rsp_from_report, $rose(rsp_valid_ff), $past(state_ff) == ST_REPORT)
   `MSCHED_CHECK(a_update_after_scan, state_ff == ST_UPDATE, $past(state_ff) == ST_SCAN)
   `MSCHED_CHECK_NEXT(a_tick_enters_scan, cmd.tick_start, state_ff == ST_SCAN)
endmodule
`default_nettype wire

// ===== rtl/core/msched_dpath.sv =====
`default_nettype none
module msched_dpath #(
   parameter int MAX_PROCS  = 16,
   parameter int NUM_LEVELS = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [msched_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [msched_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  wire msched_pkg::req_payload_type           req_data,
   input  wire msched_pkg::cmd_type                   cmd,
   output msched_pkg::sts_type                        sts,
   output msched_pkg::rsp_payload_type                rsp_data
);
   import msched_pkg::*;

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   typedef struct packed {
      logic [7:0]         pid;
      logic [15:0]        arrival;
      logic [15:0]        burst;
      logic [15:0]        remaining;
      logic [LEVEL_W-1:0] level;
      logic [15:0]        slice_used;
      logic [31:0]        first_run;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   function automatic logic [31:0] sat_inc(input logic [31:0] a);
      sat_inc = (a == '1) ? a : a + 32'd1;
   endfunction

   function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
      sat_sub = (a > b) ? a - b : '0;
   endfunction

   // configuration
   logic [LCNT_W-1:0] num_levels_ff, num_levels_in;
   logic [15:0]       boost_interval_ff, boost_interval_in;
   logic [15:0]       quantum_ff [QUANTA];
   logic [15:0]       quantum_in [QUANTA];

   // scheduler state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       clock_ff, clock_in;
   logic [31:0]       tsb_ff, tsb_in;

   // per-tick scan state
   logic              boost_ff, boost_in;
   logic [LCNT_W-1:0] levels_ff, levels_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              vld_ff, vld_in;
   logic [IDX_W-1:0]  vidx_ff, vidx_in;
   logic [LCNT_W-1:0] best_ff, best_in;
   logic              found_ff, found_in;
   slot_type          sel_ff, sel_in;
   logic [IDX_W-1:0]  sel_idx_ff, sel_idx_in;

   // tick summary held between update and report
   logic [31:0]        h_time_ff, h_time_in;
   logic               h_ran_ff, h_ran_in;
   logic [7:0]         h_pid_ff, h_pid_in;
   logic [LEVEL_W-1:0] h_lvl_ff, h_lvl_in;
   logic               h_fin_ff, h_fin_in;
   logic [31:0]        h_tat_ff, h_tat_in;
   logic [31:0]        h_first_ff, h_first_in;
   logic [15:0]        h_arr_ff, h_arr_in;
   logic [15:0]        h_burst_ff, h_burst_in;

   rsp_payload_type    rsp_ff, rsp_in;

   // table memory
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_data;

   // combinational helpers
   logic [LCNT_W-1:0] levels_clamp;
   slot_type          rd_slot, eff_slot, new_slot, upd_slot;
   logic              eligible;
   logic [15:0]       slice_inc;
   logic [31:0]       tat_calc;
   logic              fin_calc;

   msched_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PROCS)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (num_levels_ff == '0) begin
         levels_clamp = LCNT_W'(1);
      end else if (num_levels_ff > LCNT_W'(NUM_LEVELS)) begin
         levels_clamp = LCNT_W'(NUM_LEVELS);
      end else begin
         levels_clamp = num_levels_ff;
      end

      new_slot            = '0;
      new_slot.pid        = req_data.proc_id;
      new_slot.arrival    = req_data.arrival;
      new_slot.burst      = req_data.burst;
      new_slot.remaining  = req_data.burst;

      rd_slot  = slot_type'(ram_rd_data);
      eff_slot = rd_slot;
      if (boost_ff && rd_slot.remaining != '0) begin
         eff_slot.level      = '0;
         eff_slot.slice_used = '0;
      end
      eligible = ({16'd0, rd_slot.arrival} <= clock_ff) && (rd_slot.remaining != '0) &&
                 ({1'b0, eff_slot.level} < best_ff);

      // run the selected slot for one tick
      upd_slot = sel_ff;
      if (sel_ff.remaining == sel_ff.burst) begin
         upd_slot.first_run = clock_ff;
      end
      upd_slot.remaining = sel_ff.remaining - 16'd1;
      slice_inc = (sel_ff.slice_used == '1) ? sel_ff.slice_used : sel_ff.slice_used + 16'd1;
      upd_slot.slice_used = slice_inc;
      fin_calc = (sel_ff.remaining == 16'd1);
      tat_calc = (clock_ff - {16'd0, sel_ff.arrival}) + {31'd0, clock_ff != '1};
      if (!fin_calc && slice_inc >= quantum_ff[sel_ff.level]) begin
         if ({1'b0, sel_ff.level} + LCNT_W'(1) < levels_ff) begin
            upd_slot.level = sel_ff.level + LEVEL_W'(1);
         end
         upd_slot.slice_used = '0;
      end
   end

   always_comb begin
      num_levels_in     = num_levels_ff;
      boost_interval_in = boost_interval_ff;
      quantum_in        = quantum_ff;
      count_in          = count_ff;
      clock_in          = clock_ff;
      tsb_in            = tsb_ff;
      boost_in          = boost_ff;
      levels_in         = levels_ff;
      rd_ptr_in         = rd_ptr_ff;
      vld_in            = 1'b0;
      vidx_in           = vidx_ff;
      best_in           = best_ff;
      found_in          = found_ff;
      sel_in            = sel_ff;
      sel_idx_in        = sel_idx_ff;
      h_time_in         = h_time_ff;
      h_ran_in          = h_ran_ff;
      h_pid_in          = h_pid_ff;
      h_lvl_in          = h_lvl_ff;
      h_fin_in          = h_fin_ff;
      h_tat_in          = h_tat_ff;
      h_first_in        = h_first_ff;
      h_arr_in          = h_arr_ff;
      h_burst_in        = h_burst_ff;
      rsp_in            = rsp_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = count_ff[IDX_W-1:0];
      ram_wr_data       = SLOT_W'(new_slot);
      ram_rd_en         = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_LEVELS: num_levels_in     = csr_wr_data[LCNT_W-1:0];
            CSR_BOOST:      boost_interval_in = csr_wr_data;
            CSR_QUANTUM0:   quantum_in[0]     = csr_wr_data;
            CSR_QUANTUM1:   quantum_in[1]     = csr_wr_data;
            CSR_QUANTUM2:   quantum_in[2]     = csr_wr_data;
            CSR_QUANTUM3:   quantum_in[3]     = csr_wr_data;
            default: ;
         endcase
      end

      if (cmd.load && count_ff < CNT_W'(MAX_PROCS)) begin
         ram_wr_en = 1'b1;
         count_in  = count_ff + CNT_W'(1);
      end

      if (cmd.clear) begin
         count_in = '0;
         clock_in = '0;
         tsb_in   = '0;
      end

      if (cmd.tick_start) begin
         boost_in  = (tsb_ff >= {16'd0, boost_interval_ff});
         if (tsb_ff >= {16'd0, boost_interval_ff}) begin
            tsb_in = '0;
         end
         levels_in = levels_clamp;
         best_in   = levels_clamp;
         found_in  = 1'b0;
         rd_ptr_in = '0;
      end

      if (cmd.scan) begin
         if (rd_ptr_ff != count_ff) begin
            ram_rd_en = 1'b1;
            vld_in    = 1'b1;
            vidx_in   = rd_ptr_ff[IDX_W-1:0];
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
         end
         if (vld_ff) begin
            if (boost_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = vidx_ff;
               ram_wr_data = SLOT_W'(eff_slot);
            end
            if (eligible) begin
               best_in    = {1'b0, eff_slot.level};
               found_in   = 1'b1;
               sel_in     = eff_slot;
               sel_idx_in = vidx_ff;
            end
         end
      end

      if (cmd.update) begin
         clock_in   = sat_inc(clock_ff);
         tsb_in     = sat_inc(tsb_ff);
         h_time_in  = clock_ff;
         h_ran_in   = found_ff;
         h_pid_in   = sel_ff.pid;
         h_lvl_in   = sel_ff.level;
         h_fin_in   = found_ff && fin_calc;
         h_tat_in   = tat_calc;
         h_first_in = upd_slot.first_run;
         h_arr_in   = sel_ff.arrival;
         h_burst_in = sel_ff.burst;
         if (found_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sel_idx_ff;
            ram_wr_data = SLOT_W'(upd_slot);
         end
      end

      if (cmd.report) begin
         rsp_in.tick_time  = h_time_ff;
         rsp_in.ran        = h_ran_ff;
         rsp_in.run_pid    = h_ran_ff ? h_pid_ff : '0;
         rsp_in.run_level  = h_ran_ff ? h_lvl_ff : '0;
         rsp_in.finished   = h_fin_ff;
         rsp_in.turnaround = h_fin_ff ? h_tat_ff : '0;
         rsp_in.waiting    = h_fin_ff ? sat_sub(h_tat_ff, {16'd0, h_burst_ff}) : '0;
         rsp_in.response   = h_fin_ff ? sat_sub(h_first_ff, {16'd0, h_arr_ff}) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff     <= LCNT_W'(3);
         boost_interval_ff <= 16'd50;
         quantum_ff[0]     <= 16'd2;
         quantum_ff[1]     <= 16'd4;
         quantum_ff[2]     <= 16'd8;
         quantum_ff[3]     <= 16'd16;
         count_ff          <= '0;
         clock_ff          <= '0;
         tsb_ff            <= '0;
         rd_ptr_ff         <= '0;
         vld_ff            <= 1'b0;
         found_ff          <= 1'b0;
         best_ff           <= '0;
         levels_ff         <= LCNT_W'(1);
         boost_ff          <= 1'b0;
      end else begin
         num_levels_ff     <= num_levels_in;
         boost_interval_ff <= boost_interval_in;
         quantum_ff        <= quantum_in;
         count_ff          <= count_in;
         clock_ff          <= clock_in;
         tsb_ff            <= tsb_in;
         rd_ptr_ff         <= rd_ptr_in;
         vld_ff            <= vld_in;
         found_ff          <= found_in;
         best_ff           <= best_in;
         levels_ff         <= levels_in;
         boost_ff          <= boost_in;
      end
      vidx_ff    <= vidx_in;
      sel_ff     <= sel_in;
      sel_idx_ff <= sel_idx_in;
      h_time_ff  <= h_time_in;
      h_ran_ff   <= h_ran_in;
      h_pid_ff   <= h_pid_in;
      h_lvl_ff   <= h_lvl_in;
      h_fin_ff   <= h_fin_in;
      h_tat_ff   <= h_tat_in;
      h_first_ff <= h_first_in;
      h_arr_ff   <= h_arr_in;
      h_burst_ff <= h_burst_in;
      rsp_ff     <= rsp_in;
   end

   assign sts.scan_done = (rd_ptr_ff == count_ff) && !vld_ff;
   assign rsp_data      = rsp_ff;

`include "multilevel_feedback_scheduler_unit_assert.svh"
   `MSCHED_CHECK(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_PROCS))
   `MSCHED_CHECK(a_found_below_levels, found_ff, best_ff < levels_ff)
   `MSCHED_CHECK(a_vld_after_issue, vld_ff, rd_ptr_ff != '0)
endmodule
`default_nettype wire

// ===== rtl/core/multilevel_feedback_scheduler_unit.sv =====
// Load and clear beats are taken while idle and give no result. A tick beat gives one
// result beat: its n loaded slots are scanned one slot a cycle through the table's
// single read port, then come the update and report states; the report waits until the
// output register is free, and the next beat is taken once the controller is idle again.
// Reset is synchronous: control and configuration registers return to their defaults, the
// table is emptied by zeroing its fill count, and the clock and boost counters are zeroed.
`default_nettype none
module multilevel_feedback_scheduler_unit #(
   parameter int MAX_PROCS  = 16,
   parameter int NUM_LEVELS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   msched_chan_if.sink                             req_bus,
   msched_chan_if.source                           rsp_bus,
   input  wire logic                               csr_wr_en,
   input  wire logic [msched_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [msched_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import msched_pkg::*;

   cmd_type         cmd;
   sts_type         sts;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   // Request payload travels straight to the datapath; only the controller decides
   // whether a beat is taken, so the payload is sampled on the accepting edge.
   assign req_data = req_bus.data;

   // Controller: idle / scan / update / report sequencer. It owns the request
   // ready and the response valid, and drives the datapath through cmd.
   msched_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.data.req_type),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: configuration registers, process table memory, scan and select
   // logic, slot update and the output register that holds the result beat.
   // The output register lets loads and clears proceed while a result waits.
   msched_dpath #(
      .MAX_PROCS  (MAX_PROCS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

   // Drive the response payload from the datapath output register.
   assign rsp_bus.data = rsp_data;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import msched_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int LEVEL_CAP     = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BEATS   = 130;
   localparam int REPORT_CAP    = 100;

   // request code that the block must swallow without a trace
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // register indexes beyond the defined set; writes there change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   msched_chan_if #(.payload_type(req_payload_type)) req_chan ();
   msched_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   multilevel_feedback_scheduler_unit #(
      .MAX_PROCS  (TABLE_DEPTH),
      .NUM_LEVELS (LEVEL_CAP)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_chan),
      .rsp_bus     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Mirror of the scheduler: registers, process table, clock and the
   // boost counter, all kept at the widths the block uses.
   // ---------------------------------------------------------------------
   logic [2:0]         cfg_levels;
   logic [15:0]        cfg_boost;
   logic [15:0]        cfg_quantum   [QUANTA];

   logic [7:0]         tbl_pid       [TABLE_DEPTH];
   logic [15:0]        tbl_arrival   [TABLE_DEPTH];
   logic [15:0]        tbl_burst     [TABLE_DEPTH];
   logic [15:0]        tbl_remaining [TABLE_DEPTH];
   logic [LEVEL_W-1:0] tbl_level     [TABLE_DEPTH];
   logic [15:0]        tbl_slice     [TABLE_DEPTH];
   logic [31:0]        tbl_first_run [TABLE_DEPTH];
   int unsigned        tbl_count;
   logic [31:0]        sched_clock;
   logic [31:0]        since_boost;

   // tick reports still owed by the block, oldest first
   rsp_payload_type    tick_reports_due [$];
   rsp_payload_type    due_report;

   int unsigned mismatches, n_beats, n_ticks, n_idle, n_done, n_loads, n_dropped;
   int unsigned n_clears, n_ignored, n_checked, n_settings, burst_left, cycle_count;
   int unsigned rx_mode, rx_left, rx_hold;
   bit          rx_stalled;

   function automatic logic [31:0] floor_sub(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] a);
      return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
   endfunction

   function automatic void empty_table();
      tbl_count   = 0;
      sched_clock = '0;
      since_boost = '0;
   endfunction

   function automatic void mirror_reg_write(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_NUM_LEVELS: cfg_levels = data[2:0];
         CSR_BOOST:      cfg_boost  = data;
         CSR_QUANTUM0, CSR_QUANTUM1, CSR_QUANTUM2, CSR_QUANTUM3:
            cfg_quantum[idx - CSR_QUANTUM0] = data;
         default: ;
      endcase
   endfunction

   // One tick: boost if due, pick the best arrived and unfinished slot,
   // run it, then report completion or apply demotion.
   function automatic rsp_payload_type mfq_tick();
      int unsigned     lvls, best, sel, lvl;
      bit              found;
      rsp_payload_type r;
      logic [31:0]     tat;
      lvls = cfg_levels;
      if (lvls < 1) lvls = 1;
      if (lvls > LEVEL_CAP) lvls = LEVEL_CAP;

      if (since_boost >= 32'(cfg_boost)) begin
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_remaining[i] != 0) begin
               tbl_level[i] = '0;
               tbl_slice[i] = '0;
            end
         end
         since_boost = '0;
      end

      found = 1'b0;
      sel   = 0;
      best  = lvls;
      for (int i = 0; i < tbl_count; i++) begin
         if (32'(tbl_arrival[i]) <= sched_clock && tbl_remaining[i] != 0 &&
             tbl_level[i] < best) begin
            best  = tbl_level[i];
            sel   = i;
            found = 1'b1;
         end
      end

      r = '0;
      r.tick_time = sched_clock;
      lvl = 0;
      if (found) begin
         lvl         = tbl_level[sel];
         r.ran       = 1'b1;
         r.run_pid   = tbl_pid[sel];
         r.run_level = tbl_level[sel];
         if (tbl_remaining[sel] == tbl_burst[sel]) tbl_first_run[sel] = sched_clock;
         tbl_remaining[sel] = tbl_remaining[sel] - 16'd1;
         if (tbl_slice[sel] != 16'hFFFF) tbl_slice[sel] = tbl_slice[sel] + 16'd1;
      end

      sched_clock = bump(sched_clock);
      since_boost = bump(since_boost);

      if (found) begin
         if (tbl_remaining[sel] == 0) begin
            tat          = floor_sub(sched_clock, 32'(tbl_arrival[sel]));
            r.finished   = 1'b1;
            r.turnaround = tat;
            r.waiting    = floor_sub(tat, 32'(tbl_burst[sel]));
            r.response   = floor_sub(tbl_first_run[sel], 32'(tbl_arrival[sel]));
         end else if (tbl_slice[sel] >= cfg_quantum[lvl]) begin
            // never drop below the last level in use
            if (lvl + 1 < lvls) tbl_level[sel] = LEVEL_W'(lvl + 1);
            tbl_slice[sel] = '0;
         end
      end
      return r;
   endfunction

   // Advance the mirror by one accepted beat and queue any report it owes.
   function automatic void apply_beat(req_payload_type b);
      rsp_payload_type r;
      case (b.req_type)
         REQ_LOAD: begin
            n_loads++;
            if (tbl_count < TABLE_DEPTH) begin
               tbl_pid[tbl_count]       = b.proc_id;
               tbl_arrival[tbl_count]   = b.arrival;
               tbl_burst[tbl_count]     = b.burst;
               tbl_remaining[tbl_count] = b.burst;
               tbl_level[tbl_count]     = '0;
               tbl_slice[tbl_count]     = '0;
               tbl_first_run[tbl_count] = '0;
               tbl_count++;
            end else begin
               n_dropped++;
            end
         end
         REQ_CLEAR: begin
            n_clears++;
            empty_table();
         end
         REQ_TICK: begin
            r = mfq_tick();
            n_ticks++;
            if (!r.ran) n_idle++;
            if (r.finished) n_done++;
            tick_reports_due.push_back(r);
         end
         default: n_ignored++;
      endcase
   endfunction

   function automatic req_payload_type make_beat(logic [1:0] kind, logic [7:0] pid,
                                                 logic [15:0] arr, logic [15:0] bur);
      req_payload_type b;
      b.req_type = kind;
      b.proc_id  = pid;
      b.arrival  = arr;
      b.burst    = bur;
      return b;
   endfunction

   function automatic logic [15:0] pick_quantum();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'd0;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom_range(1, 8));
   endfunction

   // ---------------------------------------------------------------------
   // Checking: one line per mismatch, printing capped, counting never.
   // ---------------------------------------------------------------------
   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatches < REPORT_CAP)
         $display("[%0t] %s differs: got 0x%0h, predicted 0x%0h", $realtime, field, got, want);
      mismatches++;
   endtask

   // Sample the result channel at the rising edge and compare with the oldest report.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (tick_reports_due.size() == 0) begin
            flag_mismatch("unrequested result beat", rsp_chan.data.tick_time, '0);
         end else begin
            due_report = tick_reports_due.pop_front();
            n_checked++;
            if (rsp_chan.data.tick_time !== due_report.tick_time)
               flag_mismatch("tick_time", rsp_chan.data.tick_time, due_report.tick_time);
            if (rsp_chan.data.ran !== due_report.ran)
               flag_mismatch("ran", rsp_chan.data.ran, due_report.ran);
            if (rsp_chan.data.run_pid !== due_report.run_pid)
               flag_mismatch("run_pid", rsp_chan.data.run_pid, due_report.run_pid);
            if (rsp_chan.data.run_level !== due_report.run_level)
               flag_mismatch("run_level", rsp_chan.data.run_level, due_report.run_level);
            if (rsp_chan.data.finished !== due_report.finished)
               flag_mismatch("finished", rsp_chan.data.finished, due_report.finished);
            if (rsp_chan.data.turnaround !== due_report.turnaround)
               flag_mismatch("turnaround", rsp_chan.data.turnaround, due_report.turnaround);
            if (rsp_chan.data.waiting !== due_report.waiting)
               flag_mismatch("waiting", rsp_chan.data.waiting, due_report.waiting);
            if (rsp_chan.data.response !== due_report.response)
               flag_mismatch("response", rsp_chan.data.response, due_report.response);
         end
      end
   end

   // Watchdog: give up well past the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("watchdog expired with %0d reports outstanding", tick_reports_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver back-pressure: segments of always-ready, scattered stalls and
   // long stall runs, each lasting a random number of cycles.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_left = $urandom_range(40, 300);
      end
      rx_left--;
      case (rx_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (rx_hold == 0) begin
               rx_stalled = !rx_stalled;
               rx_hold    = rx_stalled ? $urandom_range(1, 30) : $urandom_range(1, 4);
            end
            rx_hold--;
            rsp_chan.ready <= !rx_stalled;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sender: beats go out in bursts of random length with random gaps.
   // Drive at the falling edge, hold until the rising edge that takes it.
   // ---------------------------------------------------------------------
   task automatic send_beat(input req_payload_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.data  <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      apply_beat(b);
      if (b.req_type != REQ_UNUSED) n_beats++;
   endtask

   task automatic send_tick();
      send_beat(make_beat(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   // Let every owed report come home, then give the block time to settle.
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tick_reports_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      mirror_reg_write(idx, data);
   endtask

   // Rewrite every register, spare indexes too, once the block is idle.
   task automatic set_config(input logic [2:0] levels, input logic [15:0] boost,
                             input logic [15:0] q0, input logic [15:0] q1,
                             input logic [15:0] q2, input logic [15:0] q3);
      wait_idle();
      // upper data bits are junk: only the low three bits count
      write_reg(CSR_NUM_LEVELS, {13'($urandom), levels});
      write_reg(CSR_BOOST, boost);
      write_reg(CSR_QUANTUM0, q0);
      write_reg(CSR_QUANTUM1, q1);
      write_reg(CSR_QUANTUM2, q2);
      write_reg(CSR_QUANTUM3, q3);
      write_reg(CSR_SPARE_LO, 16'($urandom));
      write_reg(CSR_SPARE_HI, 16'($urandom));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes under the reset settings: a one-tick process, one that
   // never arrives, one born finished, and an unused request code.
   task automatic test_field_extremes();
      send_beat(make_beat(REQ_CLEAR, 8'h00, 16'h0000, 16'h0000));
      send_beat(make_beat(REQ_LOAD, 8'hFF, 16'h0000, 16'h0001));
      send_beat(make_beat(REQ_LOAD, 8'h00, 16'hFFFF, 16'hFFFF));
      send_beat(make_beat(REQ_LOAD, 8'h5A, 16'h0000, 16'h0000));
      send_beat(make_beat(REQ_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF));
      repeat (3) send_tick();
   endtask

   // Fill the table to the brim, push one more load that must be dropped,
   // then tick so the first eligible slots run, the first to completion.
   task automatic test_table_overflow();
      for (int i = 0; i < 14; i++)
         send_beat(make_beat(REQ_LOAD, 8'(8'h10 + i), 16'(i % 3), 16'(1 + i % 4)));
      repeat (2) send_tick();
   endtask

   // Mostly well-formed episodes: a few loads, then ticks sized from their bursts
   // and capped; sprinkled with clears, runs of bare ticks and unused codes.
   task automatic run_traffic(input int unsigned target);
      int unsigned start, roll, k, ticks;
      logic [15:0] arr, bur;
      start = n_beats;
      while (n_beats - start < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            send_beat(make_beat(REQ_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom)));
         end else if (roll < 10 || (tbl_count >= 12 && roll < 55)) begin
            send_beat(make_beat(REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom)));
         end else if (roll < 16) begin
            repeat ($urandom_range(1, 6)) send_tick();
         end else begin
            k     = $urandom_range(1, 5);
            ticks = $urandom_range(0, 4);
            repeat (k) begin
               roll = $urandom_range(0, 19);
               if (roll < 14)
                  arr = (sched_clock + 8 > 32'hFFFF) ? 16'hFFFF :
                        16'(sched_clock + $urandom_range(0, 8));
               else if (roll < 17)
                  arr = 16'($urandom_range(0, (sched_clock > 32'hFFFF) ? 32'hFFFF : sched_clock));
               else
                  arr = 16'($urandom);
               roll = $urandom_range(0, 31);
               if (roll < 2)      bur = 16'd0;
               else if (roll < 3) bur = 16'($urandom_range(1, 65535));
               else if (roll < 6) bur = 16'($urandom_range(7, 40));
               else               bur = 16'($urandom_range(1, 6));
               ticks += (bur <= 40) ? bur : 8;
               send_beat(make_beat(REQ_LOAD, 8'($urandom), arr, bur));
            end
            if (ticks > 60) ticks = 60;
            repeat (ticks) send_tick();
         end
      end
   endtask

   // Walk through a series of settings: reset values first, then the
   // extremes (boost every tick, zero and maximal quanta, out-of-range level
   // counts, levels lowered under demoted processes), then random ones.
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: ;
            1: set_config(3'd4, 16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF);
            2: set_config(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: set_config(3'd0, 16'd7, 16'd1, 16'd2, 16'd3, 16'd4);
            4: set_config(3'd7, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1);
            5: set_config(3'd2, 16'd30, 16'd2, 16'd3, 16'd4, 16'd5);
            default:
               set_config(3'($urandom_range(0, 7)),
                          ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 60)),
                          pick_quantum(), pick_quantum(), pick_quantum(), pick_quantum());
         endcase
         // keep the table across the level cut so stranded processes show up
         if (phase != 5 && $urandom_range(0, 1) == 1)
            send_beat(make_beat(REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom)));
         run_traffic(PHASE_BEATS);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wr_data     = '0;
      req_chan.valid  = 1'b0;
      req_chan.data   = '0;
      rsp_chan.ready  = 1'b0;
      cfg_levels      = 3'd3;
      cfg_boost       = 16'd50;
      cfg_quantum[0]  = 16'd2;
      cfg_quantum[1]  = 16'd4;
      cfg_quantum[2]  = 16'd8;
      cfg_quantum[3]  = 16'd16;
      empty_table();

      // hold reset, then release it on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_table_overflow();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats over %0d register settings: %0d ticks, %0d idle, %0d done",
               n_beats, n_settings + 1, n_ticks, n_idle, n_done);
      $display("loads %0d (%0d dropped when full), clears %0d, unused codes %0d, checked %0d",
               n_loads, n_dropped, n_clears, n_ignored, n_checked);
      if (mismatches == 0 && tick_reports_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d reports never arrived", mismatches,
                  tick_reports_due.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
